[design/rcp_pkg.sv]
// Shared types, codes, defaults and fixed-point helpers for the covariate projection core.
`default_nettype none

package rcp_pkg;

   localparam int DEF_MAX_FACTORS    = 16;
   localparam int DEF_MAX_COVARIATES = 8;
   localparam int DEF_MAX_ROWS       = 1024;

   // Input word modes.
   localparam logic [1:0] MODE_LOAD_SCORE   = 2'd0;
   localparam logic [1:0] MODE_LOAD_COVAR   = 2'd1;
   localparam logic [1:0] MODE_LOAD_LOADING = 2'd2;
   localparam logic [1:0] MODE_SAMPLE       = 2'd3;

   // Register indexes, taken from paddr[2].
   localparam logic REG_NUM_FACTORS    = 1'b0;
   localparam logic REG_NUM_COVARIATES = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FACT,
      ST_ROUND,
      ST_COV,
      ST_EMIT
   } rcp_state_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add64 = s[63:0];
      end
   endfunction

   function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         sat_sub64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_sub64 = s[63:0];
      end
   endfunction

   // Q32.32 to Q16.16 with round half up, then saturate to 32 bits.
   function automatic logic signed [31:0] to_q16(input logic signed [63:0] x);
      logic signed [64:0] t;
      logic signed [48:0] q;
      t = {x[63], x} + 65'sd32768;
      q = t[64:16];
      if (q[48:31] == {18{1'b0}} || q[48:31] == {18{1'b1}}) begin
         to_q16 = q[31:0];
      end else begin
         to_q16 = q[48] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

[design/rcp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rcp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/residual_covariate_projection_core.sv]
// Top level of the residual covariate projection core: sequencer, shared MAC and accumulators.
//
// Usage: the req_ channel carries one word per cycle at most. Modes 0, 1 and 2 load the
// factor scores U, the covariates C and the current column's loadings V; a load leaves
// req_ready high, so the next word can follow in the next cycle. Mode 3 brings the
// sample R[i] of one row. The core forms R[i] - sum_k U[k][i]V[k] and then adds
// C[i][d] times that residual into accumulator d for every covariate d.
// A sample holds req_ready low while it runs (K factors, D covariates): one shared 32x32
// multiplier takes one U or C read from the score or covariate RAM per cycle, each read
// passing the RAM read register and the product register; a pass ends once both are empty,
// and a rounding state lies between the factor and covariate passes. A pass with no work
// (row beyond the store, or K or D of zero) issues no reads. On a sample with last_row set
// the core then hands out D words on the rsp_ channel, one per cycle while the receiver
// takes them, with rsp_last on the final one, and clears the accumulators. A stalled receiver
// holds the output register; the core waits with it and takes the next request word as soon
// as the final result sits in the output register. num_factors and num_covariates are written
// through the APB port while the core is idle; the user must see to this, as the core
// does not enforce it. Reset returns both registers to 1 and clears the accumulators and
// rsp_valid. The U, C and V stores hold no defined content until written.
`default_nettype none

module residual_covariate_projection_core
   import rcp_pkg::*;
#(
   parameter int MAX_FACTORS    = DEF_MAX_FACTORS,
   parameter int MAX_COVARIATES = DEF_MAX_COVARIATES,
   parameter int MAX_ROWS       = DEF_MAX_ROWS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [9:0]         req_row_index,
   input  wire logic [3:0]         req_entry_index,
   input  wire logic signed [31:0] req_value,
   input  wire logic               req_last_row,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_covariate_index,
   output logic signed [63:0]      rsp_projection,
   output logic                    rsp_last,
   // APB configuration port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);

   localparam int MAX_ENTRIES = (MAX_FACTORS > MAX_COVARIATES) ? MAX_FACTORS : MAX_COVARIATES;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int FIDX_W = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
   localparam int CIDX_W = (MAX_COVARIATES > 1) ? $clog2(MAX_COVARIATES) : 1;
   localparam int UA_W   = $clog2(MAX_FACTORS * MAX_ROWS);
   localparam int CA_W   = $clog2(MAX_ROWS * MAX_COVARIATES);

   // Configuration registers.
   logic [4:0] num_factors_ff;
   logic [3:0] num_covariates_ff;
   logic       csr_write;

   // Sequencer state.
   rcp_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [9:0]         row_ff, row_in;
   logic               row_ok_ff, row_ok_in;
   logic               last_ff, last_in;
   logic signed [63:0] res_ff, res_in;
   logic signed [31:0] r16_ff, r16_in;

   // Read and multiply pipeline.
   logic               rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]   rd_idx_ff;
   logic               mul_vld_ff;
   logic [CNT_W-1:0]   mul_idx_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] mul_a, mul_b;
   logic               issue;

   // Stores.
   logic signed [31:0] loadings_ff [MAX_FACTORS];
   logic signed [63:0] acc_ff [MAX_COVARIATES];
   logic [CIDX_W-1:0]  acc_raddr;
   logic signed [63:0] acc_rdata;
   logic               acc_we;
   logic               acc_clear;

   logic [CNT_W-1:0]   kc, dc;
   logic               req_row_ok;
   logic               accept;
   logic               u_we, c_we, v_we;
   logic [UA_W-1:0]    u_waddr, u_raddr;
   logic [CA_W-1:0]    c_waddr, c_raddr;
   logic [31:0]        u_rdata, c_rdata;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_idx_ff;
   logic signed [63:0] rsp_proj_ff;
   logic               rsp_last_ff;
   logic               emit_load;
   logic               emit_last;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_factors_ff    <= 5'd1;
         num_covariates_ff <= 4'd1;
      end else if (csr_write) begin
         case (paddr[2])
            REG_NUM_FACTORS:    num_factors_ff    <= pwdata[4:0];
            REG_NUM_COVARIATES: num_covariates_ff <= pwdata[3:0];
            default:            num_factors_ff    <= num_factors_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_NUM_FACTORS:    prdata = {27'd0, num_factors_ff};
         REG_NUM_COVARIATES: prdata = {28'd0, num_covariates_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // Register values beyond the store depth act as the depth.
   always_comb begin
      if (num_factors_ff >= MAX_FACTORS) begin
         kc = CNT_W'(MAX_FACTORS);
      end else begin
         kc = CNT_W'(num_factors_ff);
      end
      if (num_covariates_ff >= MAX_COVARIATES) begin
         dc = CNT_W'(MAX_COVARIATES);
      end else begin
         dc = CNT_W'(num_covariates_ff);
      end
   end

   // ---------------- loads ----------------
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign req_row_ok = (req_row_index < MAX_ROWS);

   assign u_we = accept && (req_mode == MODE_LOAD_SCORE) && req_row_ok &&
                 (req_entry_index < MAX_FACTORS);
   assign c_we = accept && (req_mode == MODE_LOAD_COVAR) && req_row_ok &&
                 (req_entry_index < MAX_COVARIATES);
   assign v_we = accept && (req_mode == MODE_LOAD_LOADING) &&
                 (req_entry_index < MAX_FACTORS);

   // U is stored factor-major, C row-major.
   assign u_waddr = UA_W'(req_entry_index) * UA_W'(MAX_ROWS) + UA_W'(req_row_index);
   assign c_waddr = CA_W'(req_row_index) * CA_W'(MAX_COVARIATES) + CA_W'(req_entry_index);
   assign u_raddr = UA_W'(cnt_ff) * UA_W'(MAX_ROWS) + UA_W'(row_ff);
   assign c_raddr = CA_W'(row_ff) * CA_W'(MAX_COVARIATES) + CA_W'(cnt_ff);

   rcp_ram #(
      .WIDTH (32),
      .DEPTH (MAX_FACTORS * MAX_ROWS)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (u_we),
      .wr_addr (u_waddr),
      .wr_data (req_value),
      .rd_en   (issue && (state_ff == ST_FACT)),
      .rd_addr (u_raddr),
      .rd_data (u_rdata)
   );

   rcp_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ROWS * MAX_COVARIATES)
   ) u_covar_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (req_value),
      .rd_en   (issue && (state_ff == ST_COV)),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   always_ff @(posedge clock) begin
      if (v_we) begin
         loadings_ff[FIDX_W'(req_entry_index)] <= req_value;
      end
   end

   // ---------------- sequencer ----------------
   assign emit_last = (cnt_ff == dc - CNT_W'(1));

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      row_in    = row_ff;
      row_ok_in = row_ok_ff;
      last_in   = last_ff;
      res_in    = res_ff;
      r16_in    = r16_ff;
      issue     = 1'b0;
      acc_clear = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_SAMPLE)) begin
               row_in    = req_row_index;
               row_ok_in = req_row_ok;
               last_in   = req_last_row;
               res_in    = {{16{req_value[31]}}, req_value, 16'd0};
               cnt_in    = '0;
               state_in  = ST_FACT;
            end
         end
         ST_FACT: begin
            if (row_ok_ff && (cnt_ff < kc)) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_ROUND;
            end
            if (mul_vld_ff) begin
               res_in = sat_sub64(res_ff, prod_ff);
            end
         end
         ST_ROUND: begin
            r16_in   = to_q16(res_ff);
            cnt_in   = '0;
            state_in = ST_COV;
         end
         ST_COV: begin
            if (row_ok_ff && (cnt_ff < dc)) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (!rd_vld_ff && !mul_vld_ff) begin
               if (last_ff && (dc != '0)) begin
                  cnt_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  // A last row with no covariates still clears the sums.
                  acc_clear = last_ff;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit_load = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
               if (emit_last) begin
                  acc_clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      row_ok_ff <= row_ok_in;
      last_ff   <= last_in;
      res_ff    <= res_in;
      r16_ff    <= r16_in;
   end

   // ---------------- shared multiplier ----------------
   assign rd_vld_in = issue;
   assign mul_a     = (state_ff == ST_FACT) ? $signed(u_rdata) : $signed(c_rdata);
   assign mul_b     = (state_ff == ST_FACT) ? loadings_ff[rd_idx_ff[FIDX_W-1:0]] : r16_ff;
   assign prod_in   = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= cnt_ff;
      mul_idx_ff <= rd_idx_ff;
      prod_ff    <= prod_in;
   end

   // ---------------- accumulators ----------------
   // Accumulation and emission never share a cycle, so one read port serves both.
   assign acc_raddr = (state_ff == ST_EMIT) ? cnt_ff[CIDX_W-1:0] : mul_idx_ff[CIDX_W-1:0];
   assign acc_rdata = acc_ff[acc_raddr];
   assign acc_we    = mul_vld_ff && (state_ff == ST_COV);

   always_ff @(posedge clock) begin
      if (reset || acc_clear) begin
         for (int i = 0; i < MAX_COVARIATES; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (acc_we) begin
         acc_ff[acc_raddr] <= sat_add64(acc_rdata, prod_ff);
      end
   end

   // ---------------- output register ----------------
   assign rsp_valid_in = emit_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_idx_ff  <= 3'(cnt_ff);
         rsp_proj_ff <= acc_rdata;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_covariate_index = rsp_idx_ff;
   assign rsp_projection      = rsp_proj_ff;
   assign rsp_last            = rsp_last_ff;

   // ---------------- assertions ----------------
   a_read_in_pass: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_FACT || state_ff == ST_COV))
      else $error("RAM read data arrived outside a factor or covariate pass");

   a_mac_in_pass: assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff |-> (state_ff == ST_FACT || state_ff == ST_COV))
      else $error("product arrived outside a factor or covariate pass");

   a_fact_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FACT) |-> (cnt_ff <= kc))
      else $error("factor counter ran past the factor count");

   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (emit_load && emit_last) |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final result word not flagged or sequencer not idle");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff || mul_vld_ff) |-> !req_ready)
      else $error("request taken while a multiply-accumulate is in flight");

endmodule

`default_nettype wire
